### hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge while reset is released.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property checked on every rising edge, reset cycles included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/iplut_pkg.sv
// ---------------------------------------------------------------------------
// iplut_pkg
// Shared types, widths and register codes of the inverse lookup block.
// ---------------------------------------------------------------------------
package iplut_pkg;

  // Default table depth.
  localparam int MAX_POINTS_DEF = 8;

  // Field widths.
  localparam int DISP_W     = 24;
  localparam int RAW_W      = 16;
  localparam int PT_OUT_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int COUNT_W    = 4;
  localparam int NUM_PAIRS  = 4;

  // Divider widths: numerator 2*t*m + D, divisor 2*D, quotient below 2^16.
  localparam int NUM_W = 41;
  localparam int DEN_W = 25;
  localparam int QUO_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_A      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_B      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_C      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_D      = 3'd4;

  // One table point.
  typedef struct packed {
    logic signed [PT_OUT_W-1:0] out;
    logic [RAW_W-1:0]           raw;
  } point_t;

endpackage

### hdl/iplut_div.sv
// ---------------------------------------------------------------------------
// iplut_div
// Restoring shift-subtract divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module iplut_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [iplut_pkg::NUM_W-1:0] num,
  input  logic [iplut_pkg::DEN_W-1:0] den,
  output logic                        done,
  output logic [iplut_pkg::QUO_W-1:0] quo
);

  localparam int QW   = iplut_pkg::QUO_W;
  localparam int DW   = iplut_pkg::DEN_W;
  localparam int CNTW = $clog2(QW);

  logic [DW-1:0]   rem_r, rem_nxt;
  logic [QW-1:0]   quo_r, quo_nxt;
  logic [DW-1:0]   den_r, den_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DW:0]     trial;

  // One compare-subtract step on the partial remainder.
  assign trial = {rem_r, quo_r[QW-1]} - {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // The upper numerator bits are already below the divisor.
      rem_nxt  = num[iplut_pkg::NUM_W-1:QW];
      quo_nxt  = num[QW-1:0];
      den_nxt  = den;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial[DW]) begin
        rem_nxt = {rem_r[DW-2:0], quo_r[QW-1]};
      end else begin
        rem_nxt = trial[DW-1:0];
      end
      quo_nxt = {quo_r[QW-2:0], ~trial[DW]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNTW'(QW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### hdl/iplut_cfg.sv
// ---------------------------------------------------------------------------
// iplut_cfg
// Configuration registers, point count clamp and table point read port.
// ---------------------------------------------------------------------------
module iplut_cfg #(
  parameter int MAX_POINTS = iplut_pkg::MAX_POINTS_DEF,
  parameter int IDX_W      = $clog2(MAX_POINTS)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [iplut_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [iplut_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [IDX_W-1:0]                 rd_idx,
  output iplut_pkg::point_t                rd_pt,
  output iplut_pkg::point_t                first_pt,
  output logic [IDX_W-1:0]                 last_idx
);

  localparam int CW = iplut_pkg::COUNT_W;

  logic [CW-1:0]                      count_r;
  logic [iplut_pkg::CFG_DATA_W-1:0]   pair_r [iplut_pkg::NUM_PAIRS];
  iplut_pkg::point_t                  pts [MAX_POINTS];
  logic [CW-1:0]                      used;
  logic [CW-1:0]                      last_w;

  assign cfg_ready = 1'b1;

  // Register writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= CW'(2);
      pair_r[0] <= '0;
      pair_r[1] <= '0;
      pair_r[2] <= '0;
      pair_r[3] <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        iplut_pkg::REG_POINT_COUNT: count_r   <= cfg_data[CW-1:0];
        iplut_pkg::REG_PAIR_A:      pair_r[0] <= cfg_data;
        iplut_pkg::REG_PAIR_B:      pair_r[1] <= cfg_data;
        iplut_pkg::REG_PAIR_C:      pair_r[2] <= cfg_data;
        iplut_pkg::REG_PAIR_D:      pair_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack the points held in the pair registers.
  for (genvar g = 0; g < MAX_POINTS; g++) begin : g_pts
    assign pts[g].raw = pair_r[g/2][(g%2)*32 +: iplut_pkg::RAW_W];
    assign pts[g].out = $signed(pair_r[g/2][(g%2)*32+16 +: iplut_pkg::PT_OUT_W]);
  end

  // Count below two acts as two, above the depth as the depth.
  always_comb begin
    if (count_r < CW'(2)) begin
      used = CW'(2);
    end else if (count_r > CW'(MAX_POINTS)) begin
      used = CW'(MAX_POINTS);
    end else begin
      used = count_r;
    end
    last_w = used - 1'b1;
  end

  assign last_idx = last_w[IDX_W-1:0];
  assign rd_pt    = pts[rd_idx];
  assign first_pt = pts[0];

endmodule

### hdl/inverse_piecewise_linear_lut.sv
// ---------------------------------------------------------------------------
// inverse_piecewise_linear_lut
// Inverts a configured piecewise-linear table: display value in, raw value out.
// ---------------------------------------------------------------------------
// Usage:
//   The input channel (in_*) carries one signed Q16.8 display value per item.
//   The result channel (out_*) returns the raw value in out_tdata and the
//   clamp flag in out_tuser, one result item per input item, in order.
//   The table is to be written through the cfg_* port only while the block
//   is idle; the block does not enforce this, and cfg_ready is always high.
// Sequence:
//   An accepted item passes LAST (read the last point) and ENDS (check the
//   table ends); an item at or beyond a table end then goes to FIN. Else SRCH
//   scans k segments, one per cycle, with k from 1 to MAX_POINTS-1; a flat
//   segment or a value that no segment holds goes to FIN, an interpolated
//   item passes MUL, START and DIV, the one-bit-per-cycle divider, first.
//   One item is in work at a time; in_tready is high only while idle.
// Reset and stall:
//   Reset empties the result register, returns the sequencer to idle and
//   loads the register defaults (two points, all zero). A finished result
//   waits in the output register while the next item is accepted; a second
//   result then waits in the sequencer until the first one is taken.
// ---------------------------------------------------------------------------
module inverse_piecewise_linear_lut #(
  parameter int MAX_POINTS = iplut_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input item: [23:0] display_value
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [23:0]                      in_tdata,
  // Result item: [15:0] raw_value
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [15:0]                      out_tdata,
  // Result flag: [0] clamped
  output logic                             out_tuser,
  // Configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [iplut_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [iplut_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int DW    = iplut_pkg::DISP_W;
  localparam int RW    = iplut_pkg::RAW_W;
  localparam int OW    = iplut_pkg::PT_OUT_W;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LAST  = 3'd1;
  localparam logic [2:0] ST_ENDS  = 3'd2;
  localparam logic [2:0] ST_SRCH  = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_START = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_FIN   = 3'd7;

  logic [2:0]             state_r, state_nxt;
  logic signed [DW-1:0]   d_r, d_nxt;
  iplut_pkg::point_t      last_pt_r, last_pt_nxt;
  iplut_pkg::point_t      lo_pt_r, lo_pt_nxt;
  logic [IDX_W-1:0]       seg_r, seg_nxt;
  logic [DW-1:0]          t_r, t_nxt;
  logic [RW-1:0]          m_r, m_nxt;
  logic [DW-1:0]          den_r, den_nxt;
  logic                   neg_r, neg_nxt;
  logic [39:0]            prod_r, prod_nxt;
  logic [RW-1:0]          res_raw_r, res_raw_nxt;
  logic                   res_clamp_r, res_clamp_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [RW-1:0]          out_raw_r, out_raw_nxt;
  logic                   out_clamp_r, out_clamp_nxt;

  logic [IDX_W-1:0]       rd_idx;
  logic [IDX_W-1:0]       hi_idx;
  logic [IDX_W-1:0]       last_idx;
  iplut_pkg::point_t      rd_pt;
  iplut_pkg::point_t      first_pt;

  logic signed [DW-1:0]   first_o;
  logic signed [DW-1:0]   last_o;
  logic signed [DW-1:0]   olo;
  logic signed [DW-1:0]   ohi;
  logic                   asc;
  logic                   below_first;
  logic                   beyond_last;
  logic                   hit;
  logic signed [DW:0]     diff;
  logic [DW:0]            diff_abs;
  logic signed [OW:0]     dout;
  logic [OW:0]            dout_abs;
  logic signed [RW:0]     draw;
  logic [RW:0]            draw_abs;
  logic                   div_start;
  logic [iplut_pkg::NUM_W-1:0] div_num;
  logic [iplut_pkg::DEN_W-1:0] div_den;
  logic                   div_done;
  logic [iplut_pkg::QUO_W-1:0] div_quo;
  logic                   out_free;

  // Register file and point read port.
  iplut_cfg #(
    .MAX_POINTS (MAX_POINTS),
    .IDX_W      (IDX_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_idx    (rd_idx),
    .rd_pt     (rd_pt),
    .first_pt  (first_pt),
    .last_idx  (last_idx)
  );

  // Divider for the interpolation.
  iplut_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // The read port serves the last point first, then the segment upper ends.
  assign hi_idx = seg_r + 1'b1;
  assign rd_idx = (state_r == ST_LAST) ? last_idx : hi_idx;

  // Point outputs scaled to Q16.8 and the table direction.
  assign first_o = $signed({first_pt.out, 8'h00});
  assign last_o  = $signed({last_pt_r.out, 8'h00});
  assign olo     = $signed({lo_pt_r.out, 8'h00});
  assign ohi     = $signed({rd_pt.out, 8'h00});
  assign asc     = $signed(last_pt_r.out) >= $signed(first_pt.out);

  assign below_first = asc ? (d_r <= first_o) : (d_r >= first_o);
  assign beyond_last = asc ? (d_r >= last_o) : (d_r <= last_o);
  assign hit = asc ? ((d_r >= olo) && (d_r <= ohi)) : ((d_r <= olo) && (d_r >= ohi));

  // Segment terms: offset into the segment, its height and its raw span.
  assign diff     = {d_r[DW-1], d_r} - {olo[DW-1], olo};
  assign diff_abs = diff[DW] ? (~diff + 1'b1) : diff;
  assign dout     = {rd_pt.out[OW-1], rd_pt.out} - {lo_pt_r.out[OW-1], lo_pt_r.out};
  assign dout_abs = dout[OW] ? (~dout + 1'b1) : dout;
  assign draw     = {1'b0, rd_pt.raw} - {1'b0, lo_pt_r.raw};
  assign draw_abs = draw[RW] ? (~draw + 1'b1) : draw;

  // Rounded quotient: floor((2*t*m + D - neg) / (2*D)).
  assign div_start = (state_r == ST_START);
  assign div_num   = {prod_r, 1'b0} + {17'b0, den_r} - {40'b0, neg_r};
  assign div_den   = {den_r, 1'b0};

  assign out_free = !out_valid_r || out_tready;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    d_nxt         = d_r;
    last_pt_nxt   = last_pt_r;
    lo_pt_nxt     = lo_pt_r;
    seg_nxt       = seg_r;
    t_nxt         = t_r;
    m_nxt         = m_r;
    den_nxt       = den_r;
    neg_nxt       = neg_r;
    prod_nxt      = prod_r;
    res_raw_nxt   = res_raw_r;
    res_clamp_nxt = res_clamp_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          d_nxt     = $signed(in_tdata);
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        last_pt_nxt = rd_pt;
        state_nxt   = ST_ENDS;
      end
      ST_ENDS: begin
        res_clamp_nxt = 1'b0;
        res_raw_nxt   = last_pt_r.raw;
        lo_pt_nxt     = first_pt;
        seg_nxt       = '0;
        if (below_first) begin
          res_raw_nxt   = first_pt.raw;
          res_clamp_nxt = (d_r != first_o);
          state_nxt     = ST_FIN;
        end else if (beyond_last) begin
          res_clamp_nxt = (d_r != last_o);
          state_nxt     = ST_FIN;
        end else begin
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (hit) begin
          res_raw_nxt = lo_pt_r.raw;
          t_nxt       = diff_abs[DW-1:0];
          m_nxt       = draw_abs[RW-1:0];
          neg_nxt     = draw[RW];
          den_nxt     = {dout_abs[OW-1:0], 8'h00};
          // A flat segment returns its lower raw value.
          state_nxt   = (dout == '0) ? ST_FIN : ST_MUL;
        end else if (hi_idx == last_idx) begin
          // No segment holds the value: keep the last raw value.
          state_nxt = ST_FIN;
        end else begin
          lo_pt_nxt = rd_pt;
          seg_nxt   = hi_idx;
        end
      end
      ST_MUL: begin
        prod_nxt  = t_r * m_r;
        state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          res_raw_nxt = neg_r ? (res_raw_r - div_quo) : (res_raw_r + div_quo);
          state_nxt   = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register between the sequencer and the receiver.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_raw_nxt   = out_raw_r;
    out_clamp_nxt = out_clamp_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == ST_FIN) && out_free) begin
      out_valid_nxt = 1'b1;
      out_raw_nxt   = res_raw_r;
      out_clamp_nxt = res_clamp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    d_r         <= d_nxt;
    last_pt_r   <= last_pt_nxt;
    lo_pt_r     <= lo_pt_nxt;
    seg_r       <= seg_nxt;
    t_r         <= t_nxt;
    m_r         <= m_nxt;
    den_r       <= den_nxt;
    neg_r       <= neg_nxt;
    prod_r      <= prod_nxt;
    res_raw_r   <= res_raw_nxt;
    res_clamp_r <= res_clamp_nxt;
    out_raw_r   <= out_raw_nxt;
    out_clamp_r <= out_clamp_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_raw_r;
  assign out_tuser  = out_clamp_r;

endmodule

### hdl/iplut_checker.sv
// ---------------------------------------------------------------------------
// iplut_checker
// Port-level checks of the inverse lookup block, bound to its top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module iplut_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser
);

  // A stalled result item stays offered.
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result item dropped while stalled")

  // A stalled result item keeps its payload.
  `ASSERT_CLK(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser), "result payload changed while stalled")

  // Once an item is taken the block is busy with it.
  `ASSERT_CLK(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready |=> !in_tready && !$rose(out_tvalid), "block not busy after taking an item")

  // Reset leaves the block idle with no result pending.
  `ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> in_tready && !out_tvalid, "block not idle after reset")

endmodule

bind inverse_piecewise_linear_lut iplut_checker u_iplut_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
